// File: sv/psc_pkg.sv
// psc_pkg: widths, register codes, result codes and shared types for the
// pressure sensor temperature compensation core. No dependencies.
package psc_pkg;

  // Port widths
  localparam int RAW_W      = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int TGT_W      = 8;
  localparam int TEMP_W     = 11;
  localparam int LED_W      = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // Datapath widths
  localparam int DIFF_W      = RAW_W + 1;          // UT - AC6
  localparam int PROD_W      = 2 * DIFF_W;         // (UT - AC6) * AC5
  localparam int TRUNC_SHIFT = 15;                 // divide by 32768
  localparam int X1_W        = 18;
  localparam int DEN_SW      = X1_W + 1;           // X1 + MD, signed
  localparam int DEN_W       = DEN_SW - 1;         // |X1 + MD|
  localparam int MC_SHIFT    = 11;                 // MC * 2048
  localparam int NUM_W       = CFG_W + MC_SHIFT;   // |MC * 2048|
  localparam int QS_W        = NUM_W + 1;          // signed X2
  localparam int B5_W        = QS_W + 1;           // B5 + 8
  localparam int MAG_W       = B5_W - 1 - 4;       // |B5 + 8| / 16
  localparam int RECIP_W     = 32;
  localparam int RECIP_SHIFT = 35;
  localparam int MUL_W       = MAG_W + RECIP_W;
  localparam int Q10_W       = MUL_W - RECIP_SHIFT;
  localparam int T_W         = Q10_W + 1;

  localparam int DIV_STAGES  = NUM_W;              // one quotient bit a stage
  localparam int FRONT_ST    = 5;
  localparam int BACK_ST     = 6;
  localparam int PIPE_DEPTH  = FRONT_ST + DIV_STAGES + BACK_ST;
  localparam int CNT_W       = $clog2(PIPE_DEPTH + 1);

  // Exact floor(n / 10) for n < 2**32: (n * RECIP_10) >> RECIP_SHIFT
  localparam logic [RECIP_W-1:0] RECIP_10 = 32'hCCCC_CCCD;

  localparam logic [PROD_W-1:0] TRUNC_BIAS = PROD_W'((1 << TRUNC_SHIFT) - 1);
  localparam logic signed [B5_W-1:0] B5_ROUND = B5_W'(8);

  localparam logic signed [T_W-1:0] T_MIN = -T_W'(1024);
  localparam logic signed [T_W-1:0] T_MAX = T_W'(1023);

  // Register reset values
  localparam logic [CFG_W-1:0]        AC5_RST = 16'd32757;
  localparam logic [CFG_W-1:0]        AC6_RST = 16'd23153;
  localparam logic signed [CFG_W-1:0] MC_RST  = -16'sd8711;
  localparam logic signed [CFG_W-1:0] MD_RST  = 16'sd2868;
  localparam logic signed [TGT_W-1:0] TGT_RST = 8'sd40;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_AC5    = 3'd0,
    REG_AC6    = 3'd1,
    REG_MC     = 3'd2,
    REG_MD     = 3'd3,
    REG_TARGET = 3'd4
  } reg_idx_e;

  typedef enum logic [LED_W-1:0] {
    LED_EQUAL = 2'd0,
    LED_ABOVE = 2'd1,
    LED_BELOW = 2'd2
  } led_e;

  // Values that ride alongside the divider
  typedef struct packed {
    logic signed [X1_W-1:0] x1;
    logic                   qneg;
    logic                   err;
  } div_side_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] nq;    // numerator bits shifting out, quotient bits in
    div_side_t        side;
  } div_stage_t;

endpackage

// File: sv/psc_div.sv
// psc_div: pipelined unsigned restoring divider, one quotient bit per stage,
// with elastic valid/ready per stage. Depends on psc_pkg.
module psc_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [psc_pkg::NUM_W-1:0] num_i,
  input  logic [psc_pkg::DEN_W-1:0] den_i,
  input  psc_pkg::div_side_t       side_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [psc_pkg::NUM_W-1:0] quo_o,
  output psc_pkg::div_side_t       side_o
);
  import psc_pkg::*;

  logic [DIV_STAGES-1:0] vld_q;
  logic [DIV_STAGES-1:0] vld_in;
  logic [DIV_STAGES:0]   adv;
  div_stage_t            st_q   [DIV_STAGES];
  div_stage_t            prev_s [DIV_STAGES];
  div_stage_t            nxt_s  [DIV_STAGES];

  // A stage takes new data when it is empty or its successor moves.
  always_comb begin
    adv[DIV_STAGES] = out_ready_i;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign vld_in = {vld_q[DIV_STAGES-2:0], in_valid_i};

  assign prev_s[0] = '{den: den_i, rem: '0, nq: num_i, side: side_i};

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic           ge;

    if (k > 0) begin : g_link
      assign prev_s[k] = st_q[k-1];
    end

    assign trial = {prev_s[k].rem, prev_s[k].nq[NUM_W-1]};
    assign ge    = trial >= {1'b0, prev_s[k].den};
    assign nxt_s[k] = '{
      den:  prev_s[k].den,
      rem:  ge ? DEN_W'(trial - {1'b0, prev_s[k].den}) : trial[DEN_W-1:0],
      nq:   {prev_s[k].nq[NUM_W-2:0], ge},
      side: prev_s[k].side
    };
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (adv[k]) vld_q[k] <= vld_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (adv[k]) st_q[k] <= nxt_s[k];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[DIV_STAGES-1];
  assign quo_o       = st_q[DIV_STAGES-1].nq;
  assign side_o      = st_q[DIV_STAGES-1].side;

endmodule

// File: sv/pressure_sensor_temp_compensation_core.sv
// pressure_sensor_temp_compensation_core: calibrated temperature from a raw
// barometric sensor reading, compared against a target. Uses psc_pkg, psc_div.
//
//   channel   dir  payload
//   s_axis    in   tdata[15:0] raw_temp
//   m_axis    out  tdata[10:0] temp_celsius, [12:11] led_state; tuser div_error
//   cfg       in   cfg_we_i / cfg_addr_i / cfg_wdata_i, write only
//
// One request per cycle unless m_axis back-pressure fills the pipe (5 front stages,
// 27 divider stages of one quotient bit each, 6 back stages).
// Reset clears all valid bits and loads the default calibration words.
// Every stage holds while its successor is full and stalled; empty stages keep
// filling, so input is still taken while a result waits on m_axis.
module pressure_sensor_temp_compensation_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [psc_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] raw_temp
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [psc_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [10:0] temp, [12:11] led, zero
  output logic                          m_axis_tuser,   // [0] div_error
  input  logic                          cfg_we_i,
  input  logic [psc_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [psc_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import psc_pkg::*;

  // Calibration registers
  logic [CFG_W-1:0]        ac5_q, ac6_q;
  logic signed [CFG_W-1:0] mc_q, md_q;
  logic signed [TGT_W-1:0] tgt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac5_q <= AC5_RST;
      ac6_q <= AC6_RST;
      mc_q  <= MC_RST;
      md_q  <= MD_RST;
      tgt_q <= TGT_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_AC5:    ac5_q <= cfg_wdata_i;
        REG_AC6:    ac6_q <= cfg_wdata_i;
        REG_MC:     mc_q  <= $signed(cfg_wdata_i);
        REG_MD:     md_q  <= $signed(cfg_wdata_i);
        REG_TARGET: tgt_q <= $signed(cfg_wdata_i[TGT_W-1:0]);
        default:    ;
      endcase
    end
  end

  // ---------------- front: X1, divisor, magnitudes ----------------
  logic [FRONT_ST-1:0] vld_f_q;
  logic [FRONT_ST-1:0] vld_f_in;
  logic [FRONT_ST:0]   adv_f;
  logic                div_in_ready;

  logic signed [DIFF_W-1:0] diff_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] x1_sum;
  logic signed [X1_W-1:0]   x1_2_q, x1_3_q;
  logic signed [DEN_SW-1:0] den_3_q;
  logic signed [DEN_SW-1:0] den_neg;
  logic [CFG_W-1:0]         mc_abs;
  logic [NUM_W-1:0]         num_4_q;
  logic [DEN_W-1:0]         den_4_q;
  div_side_t                side_4_q;

  always_comb begin
    adv_f[FRONT_ST] = div_in_ready;
    for (int k = FRONT_ST - 1; k >= 0; k--) begin
      adv_f[k] = !vld_f_q[k] || adv_f[k+1];
    end
  end

  assign vld_f_in = {vld_f_q[FRONT_ST-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_f_q <= '0;
    end else begin
      for (int k = 0; k < FRONT_ST; k++) begin
        if (adv_f[k]) vld_f_q[k] <= vld_f_in[k];
      end
    end
  end

  // truncate toward zero: bias negative products before the shift
  assign x1_sum  = prod_q + $signed(prod_q[PROD_W-1] ? TRUNC_BIAS : '0);
  assign den_neg = -den_3_q;
  assign mc_abs  = mc_q[CFG_W-1] ? CFG_W'(-mc_q) : CFG_W'(mc_q);

  always_ff @(posedge clk_i) begin
    if (adv_f[0]) diff_q <= $signed({1'b0, s_axis_tdata}) - $signed({1'b0, ac6_q});
    if (adv_f[1]) prod_q <= diff_q * $signed({1'b0, ac5_q});
    if (adv_f[2]) x1_2_q <= x1_sum[X1_W+TRUNC_SHIFT-1:TRUNC_SHIFT];
    if (adv_f[3]) begin
      den_3_q <= DEN_SW'(x1_2_q) + DEN_SW'(md_q);
      x1_3_q  <= x1_2_q;
    end
    if (adv_f[4]) begin
      num_4_q       <= {mc_abs, MC_SHIFT'(0)};
      den_4_q       <= den_3_q[DEN_SW-1] ? den_neg[DEN_W-1:0] : den_3_q[DEN_W-1:0];
      side_4_q.x1   <= x1_3_q;
      side_4_q.qneg <= mc_q[CFG_W-1] ^ den_3_q[DEN_SW-1];
      side_4_q.err  <= (den_3_q == '0);
    end
  end

  assign s_axis_tready = adv_f[0];

  // ---------------- X2 = MC*2048 / (X1+MD) ----------------
  logic             div_out_valid;
  logic [NUM_W-1:0] quo;
  div_side_t        side_d;
  logic             div_out_ready;

  psc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld_f_q[FRONT_ST-1]),
    .in_ready_o  (div_in_ready),
    .num_i       (num_4_q),
    .den_i       (den_4_q),
    .side_i      (side_4_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (div_out_ready),
    .quo_o       (quo),
    .side_o      (side_d)
  );

  // ---------------- back: B5, /16, /10, saturate, compare ----------------
  logic [BACK_ST-1:0] vld_b_q;
  logic [BACK_ST-1:0] vld_b_in;
  logic [BACK_ST:0]   adv_b;

  logic signed [QS_W-1:0]  x2_q;
  logic signed [X1_W-1:0]  x1_b0_q;
  logic [BACK_ST-2:0]      err_q;     // err_q[k] belongs to back stage k
  logic signed [B5_W-1:0]  b5p8_q;
  logic signed [B5_W-1:0]  b5p8_neg;
  logic [B5_W-2:0]         b5_abs;
  logic                    neg_2_q, neg_3_q;
  logic [MAG_W-1:0]        mag_q;
  logic [MUL_W-1:0]        mul_q;
  logic [Q10_W-1:0]        q10;
  logic signed [T_W-1:0]   t_q;
  logic signed [T_W-1:0]   tgt_ext;
  logic signed [TEMP_W-1:0] temp_d, temp_q;
  led_e                    led_d, led_q;
  logic                    err_out_q;

  always_comb begin
    adv_b[BACK_ST] = m_axis_tready;
    for (int k = BACK_ST - 1; k >= 0; k--) begin
      adv_b[k] = !vld_b_q[k] || adv_b[k+1];
    end
  end

  assign vld_b_in      = {vld_b_q[BACK_ST-2:0], div_out_valid};
  assign div_out_ready = adv_b[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= '0;
    end else begin
      for (int k = 0; k < BACK_ST; k++) begin
        if (adv_b[k]) vld_b_q[k] <= vld_b_in[k];
      end
    end
  end

  assign b5p8_neg = -b5p8_q;
  assign b5_abs   = b5p8_q[B5_W-1] ? b5p8_neg[B5_W-2:0] : b5p8_q[B5_W-2:0];
  assign q10      = mul_q[MUL_W-1:RECIP_SHIFT];
  assign tgt_ext  = T_W'(tgt_q);

  always_comb begin
    if (t_q < T_MIN)      temp_d = TEMP_W'(T_MIN);
    else if (t_q > T_MAX) temp_d = TEMP_W'(T_MAX);
    else                  temp_d = t_q[TEMP_W-1:0];
    if (t_q > tgt_ext)      led_d = LED_ABOVE;
    else if (t_q < tgt_ext) led_d = LED_BELOW;
    else                    led_d = LED_EQUAL;
  end

  always_ff @(posedge clk_i) begin
    if (adv_b[0]) begin
      x2_q     <= side_d.qneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      x1_b0_q  <= side_d.x1;
      err_q[0] <= side_d.err;
    end
    if (adv_b[1]) begin
      b5p8_q   <= B5_W'(x1_b0_q) + B5_W'(x2_q) + B5_ROUND;
      err_q[1] <= err_q[0];
    end
    if (adv_b[2]) begin
      mag_q    <= b5_abs[B5_W-2:4];
      neg_2_q  <= b5p8_q[B5_W-1];
      err_q[2] <= err_q[1];
    end
    if (adv_b[3]) begin
      mul_q    <= mag_q * RECIP_10;
      neg_3_q  <= neg_2_q;
      err_q[3] <= err_q[2];
    end
    if (adv_b[4]) begin
      if (err_q[3])     t_q <= '0;
      else if (neg_3_q) t_q <= -$signed({1'b0, q10});
      else              t_q <= $signed({1'b0, q10});
      err_q[4] <= err_q[3];
    end
    if (adv_b[5]) begin
      temp_q    <= temp_d;
      led_q     <= led_d;
      err_out_q <= err_q[4];
    end
  end

  assign m_axis_tvalid = vld_b_q[BACK_ST-1];
  assign m_axis_tdata  = OUT_DATA_W'({led_q, temp_q});
  assign m_axis_tuser  = err_out_q;

endmodule

// File: sv/psc_checker.sv
// psc_checker: port-level checks for the compensation core, bound to the top
// level below. Depends on psc_pkg.
module psc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [psc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          cfg_we_i,
  input logic [psc_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input logic [psc_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import psc_pkg::*;

  logic                     in_fire, out_fire;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [TGT_W-1:0]  tgt_q;
  logic signed [TEMP_W-1:0] temp, tgt_ext;
  logic [LED_W-1:0]         led;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign temp     = $signed(m_axis_tdata[TEMP_W-1:0]);
  assign led      = m_axis_tdata[TEMP_W+LED_W-1:TEMP_W];
  assign tgt_ext  = TEMP_W'(tgt_q);

  // requests in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CNT_W'(in_fire) - CNT_W'(out_fire);
    end
  end

  // shadow of the target register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= TGT_RST;
    end else if (cfg_we_i && cfg_addr_i == REG_TARGET) begin
      tgt_q <= $signed(cfg_wdata_i[TGT_W-1:0]);
    end
  end

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> temp == '0)
    else $error("div_error result with nonzero temperature");

  a_led_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (led == LED_EQUAL && temp == tgt_ext) ||
                      (led == LED_ABOVE && temp > tgt_ext) ||
                      (led == LED_BELOW && temp < tgt_ext))
    else $error("led_state disagrees with temperature and target");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> cnt_q != '0)
    else $error("result without a pending request");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind pressure_sensor_temp_compensation_core psc_checker u_psc_checker (.*);

// File: verif/tb.sv
// tb: self-checking testbench for pressure_sensor_temp_compensation_core.
// Drives raw readings on s_axis with bursty timing, predicts each compensated
// temperature from psc_pkg types, and checks every m_axis result in order.
`timescale 1ns / 100ps

module tb;
  import psc_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 150;
  localparam int PHASES       = 10;

  // Calibration formula constants
  localparam longint X1_DIV    = 32768;
  localparam longint MC_MUL    = 2048;
  localparam longint ROUND_ADD = 8;
  localparam longint ROUND_DIV = 16;
  localparam longint DEG_DIV   = 10;
  localparam longint TEMP_LO   = -1024;
  localparam longint TEMP_HI   = 1023;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    led_e                     led;
    logic                     err;
  } reading_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [15:0] raw_temp
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // [10:0] temp, [12:11] led, [15:13] zero
  logic                  m_axis_tuser;         // [0] div_error
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_W-1:0]      cfg_wdata_i   = '0;

  // Predictor copy of the calibration registers
  logic [CFG_W-1:0]        coef_ac5 = AC5_RST;
  logic [CFG_W-1:0]        coef_ac6 = AC6_RST;
  logic signed [CFG_W-1:0] coef_mc  = MC_RST;
  logic signed [CFG_W-1:0] coef_md  = MD_RST;
  logic signed [TGT_W-1:0] coef_tgt = TGT_RST;

  reading_t pending_temps[$];
  int       mismatches    = 0;
  int       cycle_count   = 0;
  int       burst_left    = 0;
  int       hold_request  = 0;
  logic     gaps_on       = 1'b1;
  logic     stall_on      = 1'b1;

  pressure_sensor_temp_compensation_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pressure_sensor_temp_compensation_core regression: fail");
      $finish;
    end
  end

  function automatic reading_t compensate(input logic [RAW_W-1:0] raw);
    longint   ut, a5, a6, mc, md, tg, x1, den, b5, t, clip;
    reading_t r;
    ut = raw;
    a5 = coef_ac5;
    a6 = coef_ac6;
    mc = coef_mc;
    md = coef_md;
    tg = coef_tgt;
    x1 = ((ut - a6) * a5) / X1_DIV;
    den = x1 + md;
    r.err = (den == 0);
    if (r.err) begin
      t = 0;
    end else begin
      b5 = x1 + (mc * MC_MUL) / den;
      t = ((b5 + ROUND_ADD) / ROUND_DIV) / DEG_DIV;
    end
    clip = (t < TEMP_LO) ? TEMP_LO : (t > TEMP_HI) ? TEMP_HI : t;
    r.temp = TEMP_W'(clip);
    // LED decision uses the unsaturated temperature
    if (t > tg) begin
      r.led = LED_ABOVE;
    end else if (t < tg) begin
      r.led = LED_BELOW;
    end else begin
      r.led = LED_EQUAL;
    end
    return r;
  endfunction

  // Result checker: in-order compare against the oldest prediction
  always @(posedge clk_i) begin : check_result
    reading_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_temps.size() == 0) begin
        $display("%0t: unexpected result, expected none, got tdata=%h tuser=%b",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_temps.pop_front();
        if (m_axis_tdata[TEMP_W-1:0] !== want.temp) begin
          $display("%0t: temp_celsius expected %0d actual %0d", $time,
                   want.temp, $signed(m_axis_tdata[TEMP_W-1:0]));
          mismatches++;
        end
        if (m_axis_tdata[TEMP_W +: LED_W] !== want.led) begin
          $display("%0t: led_state expected %0d actual %0d", $time,
                   want.led, m_axis_tdata[TEMP_W +: LED_W]);
          mismatches++;
        end
        if (m_axis_tdata[OUT_DATA_W-1:TEMP_W+LED_W] !== '0) begin
          $display("%0t: tdata padding expected 0 actual %h", $time,
                   m_axis_tdata[OUT_DATA_W-1:TEMP_W+LED_W]);
          mismatches++;
        end
        if (m_axis_tuser !== want.err) begin
          $display("%0t: div_error expected %b actual %b", $time,
                   want.err, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  // Result sink: run-length stall pattern, or a long counted hold on request
  initial begin : result_sink
    int   run_left;
    int   hold_left;
    logic ready_now;
    run_left = 0;
    hold_left = 0;
    ready_now = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!stall_on) begin
        m_axis_tready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          ready_now = !ready_now;
          run_left = ready_now ? $urandom_range(1, 20) : $urandom_range(1, 10);
        end
        run_left--;
        m_axis_tready <= ready_now;
      end
    end
  end

  // Enter and leave at a falling edge; tvalid stays high for the next request
  task automatic offer_reading(input logic [RAW_W-1:0] raw);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_temps.push_back(compensate(raw));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_temps.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Leaves the write enable high; set_target, or else the caller, closes a register sequence
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (addr)
      REG_AC5:    coef_ac5 = data;
      REG_AC6:    coef_ac6 = data;
      REG_MC:     coef_mc  = data;
      REG_MD:     coef_md  = data;
      REG_TARGET: coef_tgt = data[TGT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_cal(input logic [CFG_W-1:0] ac5, input logic [CFG_W-1:0] ac6,
                          input logic [CFG_W-1:0] mc, input logic [CFG_W-1:0] md);
    write_reg(REG_AC5, ac5);
    write_reg(REG_AC6, ac6);
    write_reg(REG_MC, mc);
    write_reg(REG_MD, md);
  endtask

  task automatic set_target(input logic [TGT_W-1:0] tgt);
    write_reg(REG_TARGET, {8'($urandom), tgt});
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    offer_reading(16'h0000);
    offer_reading(16'hFFFF);
    offer_reading(16'd27898);   // datasheet sample, 15 C
    offer_reading(AC6_RST);     // offset cancels, X1 = 0
    offer_reading(16'h5555);
    offer_reading(16'hAAAA);
    drain_results();
  endtask

  task automatic test_led_compare();
    set_target(8'sd15);
    offer_reading(16'd27898);
    offer_reading(16'h0000);
    offer_reading(16'hFFFF);
    drain_results();
  endtask

  task automatic test_zero_divisor();
    // AC5 = 32768 makes X1 equal UT - AC6, so MD = -1000 zeroes X1 + MD at UT 1000
    load_cal(16'd32768, 16'd0, -16'sd8711, -16'sd1000);
    set_target(8'sd0);
    offer_reading(16'd1000);
    offer_reading(16'd999);     // divisor -1, saturates high
    offer_reading(16'd1001);    // divisor +1, saturates low
    drain_results();
  endtask

  task automatic test_calibration_extremes();
    load_cal(16'd0, 16'd0, 16'sd0, 16'sd0);
    set_target(-8'sd128);
    offer_reading(16'h0000);
    offer_reading(16'hFFFF);
    drain_results();
    load_cal(16'hFFFF, 16'hFFFF, 16'sd32767, 16'sd32767);
    set_target(8'sd127);
    offer_reading(16'h0000);
    offer_reading(16'hFFFF);
    drain_results();
    load_cal(16'hFFFF, 16'd0, -16'sd32768, -16'sd32768);
    set_target(-8'sd64);
    offer_reading(16'hFFFF);
    offer_reading(16'h0000);
    drain_results();
    load_cal(16'd1, 16'hFFFF, -16'sd32768, 16'sd32767);
    set_target(8'sd127);
    offer_reading(16'h0000);
    offer_reading(16'h0001);
    drain_results();
  endtask

  task automatic test_unknown_index();
    for (int k = 1; k <= 3; k++) begin
      write_reg(CFG_ADDR_W'(REG_TARGET + k), 16'($urandom));
    end
    cfg_we_i <= 1'b0;
    offer_reading(16'($urandom));
    offer_reading(16'($urandom));
    drain_results();
  endtask

  // Output held off long enough to fill the pipe and stall s_axis
  task automatic test_backpressure();
    stall_on = 1'b0;
    gaps_on  = 1'b0;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < PHASE_ITEMS; i++) offer_reading(16'($urandom));
    drain_results();
  endtask

  task automatic test_random_phases();
    logic [CFG_W-1:0] ac5, ac6, mc, md;
    logic [RAW_W-1:0] pivot;
    longint           x1, md_l;
    reading_t         at_pivot;
    for (int p = 0; p < PHASES; p++) begin
      stall_on = (p % 3 != 0);
      gaps_on  = (p % 4 != 1);
      ac5 = 16'($urandom);
      ac6 = 16'($urandom);
      mc  = 16'($urandom);
      pivot = 16'($urandom);
      // Place MD near -X1 of the pivot reading to hit zero and tiny divisors
      x1 = ((longint'(pivot) - longint'(ac6)) * longint'(ac5)) / X1_DIV;
      if ($urandom_range(0, 3) != 0 && x1 <= 32766 && x1 >= -32765) begin
        md_l = -x1 + longint'($urandom_range(0, 4)) - 2;
        md = CFG_W'(md_l);
      end else begin
        md = 16'($urandom);
      end
      load_cal(ac5, ac6, mc, md);
      at_pivot = compensate(pivot);
      if ($urandom_range(0, 1) == 1 && !at_pivot.err &&
          at_pivot.temp >= -128 && at_pivot.temp <= 127) begin
        set_target(at_pivot.temp[TGT_W-1:0]);
      end else begin
        set_target(8'($urandom));
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 9) < 3) begin
          offer_reading(RAW_W'(pivot + $urandom_range(0, 4) - 2));
        end else begin
          offer_reading(16'($urandom));
        end
      end
      drain_results();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_led_compare();
    test_zero_divisor();
    test_calibration_extremes();
    test_unknown_index();
    test_backpressure();
    test_random_phases();
    repeat (PIPE_DEPTH + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("pressure_sensor_temp_compensation_core regression: pass");
    end else begin
      $display("pressure_sensor_temp_compensation_core regression: fail");
    end
    $finish;
  end

endmodule
